[design/sce_pkg.sv]
package sce_pkg;

  // line store depth: at most LINE_CAPACITY - 1 characters are kept
  localparam int LINE_CAPACITY = 64;

  // result kinds
  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_ERASE   = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;
  localparam logic [1:0] KIND_CMD     = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] commands_count;
    logic [31:0] overrun_count;
  } result_t;

endpackage

[design/sce_if.sv]
interface sce_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sce_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        last;
  logic [31:0] commands_count;
  logic [31:0] overrun_count;

  modport source (output valid, output kind, output data_byte, output last,
                  output commands_count, output overrun_count, input ready);
  modport sink (input valid, input kind, input data_byte, input last,
                input commands_count, input overrun_count, output ready);
endinterface

[design/serial_command_line_editor.sv]
// Line editor for a serial terminal. Each received byte is taken on in_ch and
// turned into echo, erase, newline and command items on out_ch; cfg_echo_enable
// (written with cfg_write_en) switches echo on or off. A printable byte or an
// erase holds the block until out_ch takes the echo; with no echo the block
// goes back to idle once the byte is decoded. A line end walks the line store
// (one write port, one read port) with one compare unit: it reads and checks
// each blank trimmed from the front or the back and the first non-blank seen
// from each side (registered store read), then sends one command byte per cycle
// unless out_ch stalls. The store needs no clearing after reset; the block is
// ready straight away.
module serial_command_line_editor #(
  parameter int LINE_CAPACITY = sce_pkg::LINE_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  sce_rx_if.sink    in_ch,
  sce_res_if.source out_ch,
  input  logic      cfg_write_en,
  input  logic      cfg_echo_enable
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [AW-1:0] LEN_MAX = AW'(LINE_CAPACITY - 1);

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_PUT1    = 4'd2;
  localparam logic [3:0] S_FWD_RD  = 4'd3;
  localparam logic [3:0] S_FWD_CHK = 4'd4;
  localparam logic [3:0] S_BWD_RD  = 4'd5;
  localparam logic [3:0] S_BWD_CHK = 4'd6;
  localparam logic [3:0] S_NL      = 4'd7;
  localparam logic [3:0] S_CMD     = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [7:0]    c_r, c_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [AW-1:0] start_inc;
  logic          cr_r, cr_nxt;
  logic          echo_r, echo_nxt;
  logic [31:0]   cmd_cnt_r, cmd_cnt_nxt;
  logic [31:0]   drop_cnt_r, drop_cnt_nxt;
  logic [1:0]    pend_kind_r, pend_kind_nxt;
  logic [7:0]    pend_data_r, pend_data_nxt;

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          rd_blank;

  logic             push;
  logic             out_free;
  sce_pkg::result_t res;

  assign rd_blank  = (mem_rdata == CHAR_SPACE) || (mem_rdata == CHAR_TAB);
  assign start_inc = start_r + 1'b1;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    c_nxt         = c_r;
    len_nxt       = len_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    cr_nxt        = cr_r;
    echo_nxt      = cfg_write_en ? cfg_echo_enable : echo_r;
    cmd_cnt_nxt   = cmd_cnt_r;
    drop_cnt_nxt  = drop_cnt_r;
    pend_kind_nxt = pend_kind_r;
    pend_data_nxt = pend_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = start_r;
    push          = 1'b0;
    res.kind           = pend_kind_r;
    res.data_byte      = pend_data_r;
    res.last           = 1'b1;
    res.commands_count = cmd_cnt_r;
    res.overrun_count  = drop_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          c_nxt     = in_ch.rx_byte;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (c_r == CHAR_BS || c_r == CHAR_DEL) begin
          cr_nxt    = 1'b0;
          state_nxt = S_IDLE;
          if (len_r != '0) begin
            len_nxt = len_r - 1'b1;
            if (echo_r) begin
              pend_kind_nxt = sce_pkg::KIND_ERASE;
              pend_data_nxt = '0;
              state_nxt     = S_PUT1;
            end
          end
        end else if (c_r == CHAR_LF || c_r == CHAR_CR) begin
          if (c_r == CHAR_LF && cr_r) begin
            // second half of a cr lf pair
            cr_nxt    = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            cr_nxt    = (c_r == CHAR_CR);
            start_nxt = '0;
            end_nxt   = len_r;
            state_nxt = S_FWD_RD;
          end
        end else begin
          cr_nxt    = 1'b0;
          state_nxt = S_IDLE;
          if (echo_r) begin
            pend_kind_nxt = sce_pkg::KIND_ECHO;
            pend_data_nxt = c_r;
            state_nxt     = S_PUT1;
          end
          if (len_r != LEN_MAX) begin
            mem_we  = 1'b1;
            len_nxt = len_r + 1'b1;
          end else if (drop_cnt_r != '1) begin
            drop_cnt_nxt = drop_cnt_r + 1'b1;
          end
        end
      end
      S_PUT1: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // skip leading blanks
      S_FWD_RD: begin
        if (start_r == end_r) begin
          state_nxt = S_BWD_RD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = start_r;
          state_nxt = S_FWD_CHK;
        end
      end
      S_FWD_CHK: begin
        if (rd_blank) begin
          start_nxt = start_inc;
          state_nxt = S_FWD_RD;
        end else begin
          state_nxt = S_BWD_RD;
        end
      end
      // skip trailing blanks
      S_BWD_RD: begin
        if (end_r == start_r) begin
          len_nxt   = '0;
          state_nxt = S_NL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = end_r - 1'b1;
          state_nxt = S_BWD_CHK;
        end
      end
      S_BWD_CHK: begin
        if (rd_blank) begin
          end_nxt   = end_r - 1'b1;
          state_nxt = S_BWD_RD;
        end else begin
          cmd_cnt_nxt = cmd_cnt_r + 1'b1;
          len_nxt     = '0;
          state_nxt   = S_NL;
        end
      end
      S_NL: begin
        res.kind      = sce_pkg::KIND_NEWLINE;
        res.data_byte = '0;
        res.last      = (start_r == end_r);
        if (!echo_r || out_free) begin
          push = echo_r;
          if (start_r != end_r) begin
            mem_re    = 1'b1;
            mem_raddr = start_r;
            state_nxt = S_CMD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CMD: begin
        res.kind      = sce_pkg::KIND_CMD;
        res.data_byte = mem_rdata;
        res.last      = (start_inc == end_r);
        if (out_free) begin
          push      = 1'b1;
          start_nxt = start_inc;
          if (start_inc == end_r) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = start_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      cr_r       <= 1'b0;
      echo_r     <= 1'b1;
      cmd_cnt_r  <= '0;
      drop_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      cr_r       <= cr_nxt;
      echo_r     <= echo_nxt;
      cmd_cnt_r  <= cmd_cnt_nxt;
      drop_cnt_r <= drop_cnt_nxt;
    end
    c_r         <= c_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_data_r <= pend_data_nxt;
  end

  sce_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (len_r),
    .wdata (c_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sce_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

[design/sce_ram.sv]
module sce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sce_pkg::LINE_CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sce_out_reg.sv]
module sce_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sce_pkg::result_t res,
  output logic             free,
  sce_res_if.source        out_ch
);

  logic             valid_r;
  logic             valid_nxt;
  sce_pkg::result_t data_r;

  // slot can take a new item when empty or being drained this cycle
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (push) begin
      data_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = data_r.kind;
  assign out_ch.data_byte      = data_r.data_byte;
  assign out_ch.last           = data_r.last;
  assign out_ch.commands_count = data_r.commands_count;
  assign out_ch.overrun_count  = data_r.overrun_count;

endmodule

[design/sce_checker.sv]
module sce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic        out_last,
  input logic [31:0] out_commands_count,
  input logic [31:0] out_overrun_count
);

  // an item keeps the block busy for at least the next cycle
  busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after an item was accepted");

  // while idle, only the final result of the previous item may still wait
  idle_holds_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("block idle while a non-final result is pending");

  // marker kinds carry no byte
  marker_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == sce_pkg::KIND_ERASE || out_kind == sce_pkg::KIND_NEWLINE)
    |-> out_data_byte == 8'd0)
    else $error("erase or newline result with nonzero byte");

  stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_kind, out_data_byte, out_last,
                                                      out_commands_count, out_overrun_count}))
    else $error("stalled result changed or dropped");

endmodule

bind serial_command_line_editor sce_checker u_sce_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_data_byte      (out_ch.data_byte),
  .out_last           (out_ch.last),
  .out_commands_count (out_ch.commands_count),
  .out_overrun_count  (out_ch.overrun_count)
);
